// ===== src/rmf_pkg.sv =====
// ----------------------------------------------------------------------------
// RGB median filter package
// Shared types, codes and default sizes of the RGB median filter.
// ----------------------------------------------------------------------------
`default_nettype none

package rmf_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;
  localparam int DEF_MAX_WINDOW = 7;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd2;

  localparam logic [2:0]  RST_WINDOW_SIZE  = 3'd3;
  localparam logic [10:0] RST_IMAGE_WIDTH  = 11'd1024;
  localparam logic [10:0] RST_IMAGE_HEIGHT = 11'd1024;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PLAN,
    S_NEED,
    S_TEST,
    S_BASE,
    S_ALIGN,
    S_PASS,
    S_WAIT,
    S_DECIDE,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic       load;
    logic       sample;
    logic       decide;
    logic [2:0] bitpos;
  } sel_ctrl_t;

endpackage

`default_nettype wire

// ===== src/rgb_median_filter_top.sv =====
// ----------------------------------------------------------------------------
// RGB median filter
// Per-channel median over a clipped square window of a raster RGB stream.
//
//   channel  | signals                                   | handshake
//   pixel in | command, red, green, blue                 | pix_valid / pix_stall
//   result   | out_red, out_green, out_blue, last_of_frame | res_valid / res_stall
//   config   | cfg_index, cfg_data                       | cfg_valid / cfg_ready
//
// A transaction that yields no result ends at the window test; one that yields
// a result runs the selector: eight passes over the window, one line store
// read per cycle. Reset is synchronous and needs no clearing pass.
// A held result does not block the next pixel transaction; only loading a new
// result waits for the output register to empty.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_median_filter_top #(
  parameter int MAX_WIDTH  = rmf_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = rmf_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_WINDOW = rmf_pkg::DEF_MAX_WINDOW
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           pix_valid,
  output logic                                pix_stall,
  input  wire logic                           command,
  input  wire logic [7:0]                     red,
  input  wire logic [7:0]                     green,
  input  wire logic [7:0]                     blue,
  output logic                                res_valid,
  input  wire logic                           res_stall,
  output logic      [7:0]                     out_red,
  output logic      [7:0]                     out_green,
  output logic      [7:0]                     out_blue,
  output logic                                last_of_frame,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [rmf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [rmf_pkg::CFG_DATA_W-1:0] cfg_data
);

  import rmf_pkg::*;

  localparam int DEPTH = MAX_WINDOW * MAX_WIDTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int WB    = $clog2(MAX_WIDTH + 1);
  localparam int HB    = $clog2(MAX_HEIGHT + 1);
  localparam int LW    = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int SW    = $clog2(MAX_WINDOW);
  localparam int NW    = $clog2(MAX_WINDOW * MAX_WINDOW + 1);

  function automatic logic [AW-1:0] wrap_sub(input logic [AW-1:0] a, input logic [AW-1:0] b);
    logic [AW:0] t;
    t = {1'b0, a} + (AW+1)'(DEPTH) - {1'b0, b};
    return (a >= b) ? (a - b) : t[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a, input logic [AW-1:0] b);
    logic [AW:0] t;
    t = {1'b0, a} + {1'b0, b};
    if (t >= (AW+1)'(DEPTH)) begin
      t = t - (AW+1)'(DEPTH);
    end
    return t[AW-1:0];
  endfunction

  state_t state, state_next;

  logic [2:0]  cfg_window;
  logic [10:0] cfg_width, cfg_height;

  logic [WB-1:0] eff_w;
  logic [HB-1:0] eff_h;
  logic [SW-1:0] half;
  logic [LW-1:0] total, received;

  logic [LW-1:0] in_lin;
  logic [AW-1:0] wp;
  logic          frame_complete;
  logic [HB-1:0] out_row;
  logic [WB-1:0] out_col;
  logic [AW-1:0] out_ptr;

  logic [HB-1:0] need_r;
  logic [WB-1:0] need_c;
  logic [SW-1:0] rows_m1, cols_m1, dr0, dc0;
  logic [LW-1:0] need_lin;
  logic [NW-1:0] nsamp;
  logic [AW-1:0] row_off, base_addr, row_addr, cur_addr;
  logic [SW-1:0] ri, ci;
  logic [2:0]    bitpos;
  logic          rd_valid;

  logic [HB:0]   sum_r;
  logic [WB:0]   sum_c;
  logic [HB-1:0] lim_r, r0, need_r_n;
  logic [WB-1:0] lim_c, c0, need_c_n;
  logic [AW-1:0] next_row;

  logic          pix_acc, pix_write, res_free, last_pos;
  logic          mem_re;
  logic [23:0]   rdata;
  sel_ctrl_t     sel_ctrl;
  logic [NW-1:0] k_lo, k_hi;
  logic [7:0]    med_r, med_g, med_b;

  always_comb begin
    if (cfg_width == '0) begin
      eff_w = WB'(1);
    end else if (32'(cfg_width) > MAX_WIDTH) begin
      eff_w = WB'(MAX_WIDTH);
    end else begin
      eff_w = WB'(cfg_width);
    end
    if (cfg_height == '0) begin
      eff_h = HB'(1);
    end else if (32'(cfg_height) > MAX_HEIGHT) begin
      eff_h = HB'(MAX_HEIGHT);
    end else begin
      eff_h = HB'(cfg_height);
    end
    if (32'(cfg_window) > MAX_WINDOW) begin
      half = SW'(MAX_WINDOW / 2);
    end else begin
      half = SW'(cfg_window >> 1);
    end
  end

  assign total    = LW'(LW'(eff_w) * LW'(eff_h));
  assign received = frame_complete ? total : in_lin;

  assign sum_r    = (HB+1)'(out_row) + (HB+1)'(half);
  assign lim_r    = eff_h - HB'(1);
  assign need_r_n = (sum_r > (HB+1)'(lim_r)) ? lim_r : sum_r[HB-1:0];
  assign r0       = (out_row > HB'(half)) ? (out_row - HB'(half)) : '0;
  assign sum_c    = (WB+1)'(out_col) + (WB+1)'(half);
  assign lim_c    = eff_w - WB'(1);
  assign need_c_n = (sum_c > (WB+1)'(lim_c)) ? lim_c : sum_c[WB-1:0];
  assign c0       = (out_col > WB'(half)) ? (out_col - WB'(half)) : '0;
  assign next_row = wrap_add(row_addr, AW'(eff_w));

  assign pix_acc   = pix_valid && !pix_stall;
  assign pix_write = pix_acc && (command == CMD_PIXEL) && !frame_complete;
  assign res_free  = !res_valid || !res_stall;
  assign last_pos  = (out_row == lim_r) && (out_col == lim_c);
  assign k_lo      = (nsamp - NW'(1)) >> 1;
  assign k_hi      = nsamp >> 1;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (pix_acc) state_next = S_PLAN;
      S_PLAN:   state_next = S_NEED;
      S_NEED:   state_next = S_TEST;
      S_TEST:   state_next = (need_lin >= received) ? S_IDLE : S_BASE;
      S_BASE:   state_next = S_ALIGN;
      S_ALIGN:  state_next = S_PASS;
      S_PASS:   if (ci == cols_m1 && ri == rows_m1) state_next = S_WAIT;
      S_WAIT:   state_next = S_DECIDE;
      S_DECIDE: state_next = (bitpos == 3'd0) ? S_FINISH : S_PASS;
      S_FINISH: if (res_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    pix_stall       = 1'b1;
    cfg_ready       = 1'b0;
    mem_re          = 1'b0;
    sel_ctrl.load   = 1'b0;
    sel_ctrl.sample = rd_valid;
    sel_ctrl.decide = 1'b0;
    sel_ctrl.bitpos = bitpos;
    unique case (state)
      S_IDLE: begin
        pix_stall = 1'b0;
        cfg_ready = 1'b1;
      end
      S_BASE:   sel_ctrl.load = 1'b1;
      S_PASS:   mem_re = 1'b1;
      S_DECIDE: sel_ctrl.decide = 1'b1;
      default: begin
        pix_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      cfg_window     <= RST_WINDOW_SIZE;
      cfg_width      <= RST_IMAGE_WIDTH;
      cfg_height     <= RST_IMAGE_HEIGHT;
      in_lin         <= '0;
      wp             <= '0;
      frame_complete <= 1'b0;
      out_row        <= '0;
      out_col        <= '0;
      out_ptr        <= '0;
      res_valid      <= 1'b0;
      rd_valid       <= 1'b0;
    end else begin
      state    <= state_next;
      rd_valid <= mem_re;
      if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end
      if (pix_write) begin
        wp <= wrap_add(wp, AW'(1));
        if (in_lin + LW'(1) == total) begin
          in_lin         <= '0;
          wp             <= '0;
          frame_complete <= 1'b1;
        end else begin
          in_lin <= in_lin + LW'(1);
        end
      end
      if (state == S_FINISH && res_free) begin
        res_valid <= 1'b1;
        if (last_pos) begin
          in_lin         <= '0;
          wp             <= '0;
          frame_complete <= 1'b0;
          out_row        <= '0;
          out_col        <= '0;
          out_ptr        <= '0;
        end else begin
          out_ptr <= wrap_add(out_ptr, AW'(1));
          if (out_col == lim_c) begin
            out_col <= '0;
            out_row <= out_row + HB'(1);
          end else begin
            out_col <= out_col + WB'(1);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_WINDOW_SIZE || cfg_index == CFG_IMAGE_WIDTH ||
            cfg_index == CFG_IMAGE_HEIGHT) begin
          in_lin         <= '0;
          wp             <= '0;
          frame_complete <= 1'b0;
          out_row        <= '0;
          out_col        <= '0;
          out_ptr        <= '0;
        end
        if (cfg_index == CFG_WINDOW_SIZE) begin
          cfg_window <= cfg_data[2:0];
        end
        if (cfg_index == CFG_IMAGE_WIDTH) begin
          cfg_width <= cfg_data;
        end
        if (cfg_index == CFG_IMAGE_HEIGHT) begin
          cfg_height <= cfg_data;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_PLAN: begin
        need_r  <= need_r_n;
        need_c  <= need_c_n;
        rows_m1 <= SW'(need_r_n - r0);
        cols_m1 <= SW'(need_c_n - c0);
        dr0     <= SW'(out_row - r0);
        dc0     <= SW'(out_col - c0);
      end
      S_NEED: begin
        need_lin <= LW'(LW'(need_r) * LW'(eff_w)) + LW'(need_c);
        nsamp    <= NW'((NW'(rows_m1) + NW'(1)) * (NW'(cols_m1) + NW'(1)));
        row_off  <= AW'(AW'(dr0) * AW'(eff_w));
      end
      S_BASE: begin
        row_addr <= wrap_sub(out_ptr, row_off);
      end
      S_ALIGN: begin
        base_addr <= wrap_sub(row_addr, AW'(dc0));
        row_addr  <= wrap_sub(row_addr, AW'(dc0));
        cur_addr  <= wrap_sub(row_addr, AW'(dc0));
        ri        <= '0;
        ci        <= '0;
        bitpos    <= 3'd7;
      end
      S_PASS: begin
        if (ci == cols_m1) begin
          ci <= '0;
          if (ri != rows_m1) begin
            ri       <= ri + SW'(1);
            row_addr <= next_row;
            cur_addr <= next_row;
          end
        end else begin
          ci       <= ci + SW'(1);
          cur_addr <= wrap_add(cur_addr, AW'(1));
        end
      end
      S_DECIDE: begin
        bitpos   <= bitpos - 3'd1;
        ri       <= '0;
        ci       <= '0;
        row_addr <= base_addr;
        cur_addr <= base_addr;
      end
      S_FINISH: begin
        if (res_free) begin
          out_red       <= med_r;
          out_green     <= med_g;
          out_blue      <= med_b;
          last_of_frame <= last_pos;
        end
      end
      default: begin
        ri <= ri;
      end
    endcase
  end

  rmf_line_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (pix_write),
    .waddr (wp),
    .wdata ({red, green, blue}),
    .re    (mem_re),
    .raddr (cur_addr),
    .rdata (rdata)
  );

  rmf_select #(.NW(NW)) u_sel_r (
    .clk (clk), .ctrl (sel_ctrl), .k_lo_in (k_lo), .k_hi_in (k_hi),
    .sample (rdata[23:16]), .median (med_r)
  );

  rmf_select #(.NW(NW)) u_sel_g (
    .clk (clk), .ctrl (sel_ctrl), .k_lo_in (k_lo), .k_hi_in (k_hi),
    .sample (rdata[15:8]), .median (med_g)
  );

  rmf_select #(.NW(NW)) u_sel_b (
    .clk (clk), .ctrl (sel_ctrl), .k_lo_in (k_lo), .k_hi_in (k_hi),
    .sample (rdata[7:0]), .median (med_b)
  );

  a_complete_resets_count: assert property (@(posedge clk) disable iff (rst)
    frame_complete |-> in_lin == '0)
    else $error("input count not cleared at end of frame");

  a_read_in_range: assert property (@(posedge clk) disable iff (rst)
    state == S_PASS |-> {1'b0, cur_addr} < (AW+1)'(DEPTH))
    else $error("line store read address beyond depth");

  a_sweep_in_window: assert property (@(posedge clk) disable iff (rst)
    state == S_PASS |-> ri <= rows_m1 && ci <= cols_m1)
    else $error("window sweep left the window");

  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(state) == S_FINISH)
    else $error("result raised outside the finish step");

endmodule

`default_nettype wire

// ===== src/rmf_line_mem.sv =====
// ----------------------------------------------------------------------------
// RGB median filter line store
// Single-port write, single-port read memory with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module rmf_line_mem #(
  parameter int DEPTH = 7168,
  parameter int AW    = 13
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [23:0]   wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [23:0]   rdata
);

  logic [23:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== src/rmf_select.sv =====
// ----------------------------------------------------------------------------
// RGB median filter order-statistic selector
// Finds the two middle ranks of one channel bit by bit, one pass per bit.
// ----------------------------------------------------------------------------
`default_nettype none

module rmf_select #(
  parameter int NW = 6
) (
  input  wire logic              clk,
  input  wire rmf_pkg::sel_ctrl_t ctrl,
  input  wire logic [NW-1:0]     k_lo_in,
  input  wire logic [NW-1:0]     k_hi_in,
  input  wire logic [7:0]        sample,
  output logic      [7:0]        median
);

  import rmf_pkg::*;

  logic [7:0]    p_lo, p_hi;
  logic [NW-1:0] k_lo, k_hi, c_lo, c_hi;
  logic [7:0]    hi_mask;
  logic          hit_lo, hit_hi;
  logic [8:0]    sum;

  assign hi_mask = 8'hFF << ({1'b0, ctrl.bitpos} + 4'd1);
  assign hit_lo  = ((sample & hi_mask) == (p_lo & hi_mask)) && !sample[ctrl.bitpos];
  assign hit_hi  = ((sample & hi_mask) == (p_hi & hi_mask)) && !sample[ctrl.bitpos];
  assign sum     = {1'b0, p_lo} + {1'b0, p_hi};
  assign median  = sum[8:1];

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      p_lo <= '0;
      p_hi <= '0;
      k_lo <= k_lo_in;
      k_hi <= k_hi_in;
      c_lo <= '0;
      c_hi <= '0;
    end else if (ctrl.decide) begin
      if (k_lo >= c_lo) begin
        k_lo <= k_lo - c_lo;
        p_lo[ctrl.bitpos] <= 1'b1;
      end
      if (k_hi >= c_hi) begin
        k_hi <= k_hi - c_hi;
        p_hi[ctrl.bitpos] <= 1'b1;
      end
      c_lo <= '0;
      c_hi <= '0;
    end else if (ctrl.sample) begin
      if (hit_lo) begin
        c_lo <= c_lo + NW'(1);
      end
      if (hit_hi) begin
        c_hi <= c_hi + NW'(1);
      end
    end
  end

endmodule

`default_nettype wire
